// ===== rtl/core/pdc_pkg.sv =====
`default_nettype none

package pdc_pkg;

    localparam int COUNT_WIDTH_DEF   = 16;
    localparam int ADDRESS_WIDTH_DEF = 32;

    localparam int DATA_WIDTH  = 32;
    localparam int INDEX_WIDTH = 4;
    localparam int WCODE_WIDTH = 2;

    // Two entries keep the front and back running at one word per cycle while the output is not stalled.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_RX_REQ = 2'd2,
        CMD_TX_REQ = 2'd3
    } command_t;

    typedef enum logic [INDEX_WIDTH-1:0] {
        REG_RX_PTR      = 4'd0,
        REG_RX_CNT      = 4'd1,
        REG_TX_PTR      = 4'd2,
        REG_TX_CNT      = 4'd3,
        REG_RX_NEXT_PTR = 4'd4,
        REG_RX_NEXT_CNT = 4'd5,
        REG_TX_NEXT_PTR = 4'd6,
        REG_TX_NEXT_CNT = 4'd7,
        REG_CONTROL     = 4'd8,
        REG_STATUS      = 4'd9
    } reg_index_t;

    typedef enum logic [WCODE_WIDTH-1:0] {
        WCODE_BYTE = 2'd0,
        WCODE_HALF = 2'd1,
        WCODE_WORD = 2'd2
    } wcode_t;

    localparam int CTRL_RX_ENABLE_BIT  = 0;
    localparam int CTRL_RX_DISABLE_BIT = 1;
    localparam int CTRL_TX_ENABLE_BIT  = 8;
    localparam int CTRL_TX_DISABLE_BIT = 9;
    localparam int STAT_RX_ON_BIT      = 0;
    localparam int STAT_TX_ON_BIT      = 8;

    typedef struct packed {
        logic [1:0]             command;
        logic [INDEX_WIDTH-1:0] reg_index;
        logic [DATA_WIDTH-1:0]  write_data;
    } in_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  transfer_valid;
        logic [DATA_WIDTH-1:0] transfer_address;
        logic                  transfer_to_memory;
        logic                  end_rx;
        logic                  rx_buffers_full;
        logic                  end_tx;
        logic                  tx_buffers_empty;
    } out_t;

    // Classified word handed from the front to the back.
    typedef struct packed {
        command_t               kind;
        logic [INDEX_WIDTH-1:0] reg_index;
        logic [DATA_WIDTH-1:0]  data;
        logic                   rx_on_set;
        logic                   rx_on_clr;
        logic                   tx_on_set;
        logic                   tx_on_clr;
    } op_t;

endpackage

`default_nettype wire

// ===== rtl/core/pdc_front.sv =====
`default_nettype none

module pdc_front (
    input  wire pdc_pkg::in_t  in_word,
    output pdc_pkg::op_t       op
);

    logic is_ctrl_write;

    // Decode the control write into set and clear requests up front.
    assign is_ctrl_write = (pdc_pkg::command_t'(in_word.command) == pdc_pkg::CMD_WRITE)
                        && (in_word.reg_index == pdc_pkg::REG_CONTROL);

    always_comb begin
        op.kind      = pdc_pkg::command_t'(in_word.command);
        op.reg_index = in_word.reg_index;
        op.data      = in_word.write_data;
        op.rx_on_set = is_ctrl_write && in_word.write_data[pdc_pkg::CTRL_RX_ENABLE_BIT];
        op.rx_on_clr = is_ctrl_write && in_word.write_data[pdc_pkg::CTRL_RX_DISABLE_BIT];
        op.tx_on_set = is_ctrl_write && in_word.write_data[pdc_pkg::CTRL_TX_ENABLE_BIT];
        op.tx_on_clr = is_ctrl_write && in_word.write_data[pdc_pkg::CTRL_TX_DISABLE_BIT];
    end

endmodule

`default_nettype wire

// ===== rtl/core/pdc_queue.sv =====
`default_nettype none

module pdc_queue (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                push,
    input  wire pdc_pkg::op_t  push_op,
    output logic               full,
    input  wire                pop,
    output logic               not_empty,
    output pdc_pkg::op_t       head_op
);

    localparam int PTR_WIDTH = $clog2(pdc_pkg::QUEUE_DEPTH);
    localparam int CNT_WIDTH = $clog2(pdc_pkg::QUEUE_DEPTH + 1);

    pdc_pkg::op_t           mem_reg [pdc_pkg::QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_WIDTH'(pdc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_op   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_WIDTH'(pdc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_WIDTH'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_WIDTH'(pdc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_WIDTH'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_WIDTH'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pdc_back.sv =====
`default_nettype none

module pdc_back #(
    parameter int COUNT_WIDTH   = pdc_pkg::COUNT_WIDTH_DEF,
    parameter int ADDRESS_WIDTH = pdc_pkg::ADDRESS_WIDTH_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_write_enable,
    input  wire [pdc_pkg::WCODE_WIDTH-1:0]       cfg_write_data,
    input  wire                                  op_valid,
    input  wire pdc_pkg::op_t                    op,
    output logic                                 op_pop,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output pdc_pkg::out_t                        m_data
);

    logic [pdc_pkg::WCODE_WIDTH-1:0] wcode_reg;

    logic [ADDRESS_WIDTH-1:0] rx_ptr_reg, rx_ptr_next, rx_nptr_reg, rx_nptr_next;
    logic [ADDRESS_WIDTH-1:0] tx_ptr_reg, tx_ptr_next, tx_nptr_reg, tx_nptr_next;
    logic [COUNT_WIDTH-1:0]   rx_cnt_reg, rx_cnt_next, rx_ncnt_reg, rx_ncnt_next;
    logic [COUNT_WIDTH-1:0]   tx_cnt_reg, tx_cnt_next, tx_ncnt_reg, tx_ncnt_next;
    logic                     rx_on_reg, rx_on_next, tx_on_reg, tx_on_next;

    logic [ADDRESS_WIDTH-1:0] rx_ptr_a, tx_ptr_a;
    logic [COUNT_WIDTH-1:0]   rx_cnt_a, tx_cnt_a;
    logic [ADDRESS_WIDTH-1:0] step;

    logic                     m_valid_reg, m_valid_next;
    pdc_pkg::out_t            out_reg, out_next;

    assign op_pop  = op_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        case (pdc_pkg::wcode_t'(wcode_reg))
            pdc_pkg::WCODE_BYTE: step = ADDRESS_WIDTH'(1);
            pdc_pkg::WCODE_HALF: step = ADDRESS_WIDTH'(2);
            default:             step = ADDRESS_WIDTH'(4);
        endcase
    end

    always_comb begin
        rx_ptr_a     = rx_ptr_reg;
        rx_cnt_a     = rx_cnt_reg;
        rx_nptr_next = rx_nptr_reg;
        rx_ncnt_next = rx_ncnt_reg;
        tx_ptr_a     = tx_ptr_reg;
        tx_cnt_a     = tx_cnt_reg;
        tx_nptr_next = tx_nptr_reg;
        tx_ncnt_next = tx_ncnt_reg;
        rx_on_next   = rx_on_reg;
        tx_on_next   = tx_on_reg;
        out_next     = '0;

        case (op.kind)
            pdc_pkg::CMD_WRITE: begin
                case (op.reg_index)
                    pdc_pkg::REG_RX_PTR:      rx_ptr_a     = op.data[ADDRESS_WIDTH-1:0];
                    pdc_pkg::REG_RX_CNT:      rx_cnt_a     = op.data[COUNT_WIDTH-1:0];
                    pdc_pkg::REG_TX_PTR:      tx_ptr_a     = op.data[ADDRESS_WIDTH-1:0];
                    pdc_pkg::REG_TX_CNT:      tx_cnt_a     = op.data[COUNT_WIDTH-1:0];
                    pdc_pkg::REG_RX_NEXT_PTR: rx_nptr_next = op.data[ADDRESS_WIDTH-1:0];
                    pdc_pkg::REG_RX_NEXT_CNT: rx_ncnt_next = op.data[COUNT_WIDTH-1:0];
                    pdc_pkg::REG_TX_NEXT_PTR: tx_nptr_next = op.data[ADDRESS_WIDTH-1:0];
                    pdc_pkg::REG_TX_NEXT_CNT: tx_ncnt_next = op.data[COUNT_WIDTH-1:0];
                    default: ;
                endcase
                // Disable wins over enable.
                if (op.rx_on_set) rx_on_next = 1'b1;
                if (op.rx_on_clr) rx_on_next = 1'b0;
                if (op.tx_on_set) tx_on_next = 1'b1;
                if (op.tx_on_clr) tx_on_next = 1'b0;
            end
            pdc_pkg::CMD_READ: begin
                case (op.reg_index)
                    pdc_pkg::REG_RX_PTR:      out_next.read_data = pdc_pkg::DATA_WIDTH'(rx_ptr_reg);
                    pdc_pkg::REG_RX_CNT:      out_next.read_data = pdc_pkg::DATA_WIDTH'(rx_cnt_reg);
                    pdc_pkg::REG_TX_PTR:      out_next.read_data = pdc_pkg::DATA_WIDTH'(tx_ptr_reg);
                    pdc_pkg::REG_TX_CNT:      out_next.read_data = pdc_pkg::DATA_WIDTH'(tx_cnt_reg);
                    pdc_pkg::REG_RX_NEXT_PTR: out_next.read_data = pdc_pkg::DATA_WIDTH'(rx_nptr_reg);
                    pdc_pkg::REG_RX_NEXT_CNT: out_next.read_data = pdc_pkg::DATA_WIDTH'(rx_ncnt_reg);
                    pdc_pkg::REG_TX_NEXT_PTR: out_next.read_data = pdc_pkg::DATA_WIDTH'(tx_nptr_reg);
                    pdc_pkg::REG_TX_NEXT_CNT: out_next.read_data = pdc_pkg::DATA_WIDTH'(tx_ncnt_reg);
                    pdc_pkg::REG_STATUS: begin
                        out_next.read_data[pdc_pkg::STAT_RX_ON_BIT] = rx_on_reg;
                        out_next.read_data[pdc_pkg::STAT_TX_ON_BIT] = tx_on_reg;
                    end
                    default: ;
                endcase
            end
            pdc_pkg::CMD_RX_REQ: begin
                if (rx_on_reg && (rx_cnt_reg != '0)) begin
                    out_next.transfer_valid     = 1'b1;
                    out_next.transfer_to_memory = 1'b1;
                    out_next.transfer_address   = pdc_pkg::DATA_WIDTH'(rx_ptr_reg);
                    rx_ptr_a = rx_ptr_reg + step;
                    rx_cnt_a = rx_cnt_reg - COUNT_WIDTH'(1);
                end
            end
            default: begin
                if (tx_on_reg && (tx_cnt_reg != '0)) begin
                    out_next.transfer_valid   = 1'b1;
                    out_next.transfer_address = pdc_pkg::DATA_WIDTH'(tx_ptr_reg);
                    tx_ptr_a = tx_ptr_reg + step;
                    tx_cnt_a = tx_cnt_reg - COUNT_WIDTH'(1);
                end
            end
        endcase

        // Reload the next pair into an empty current pair, then clear next count.
        rx_ptr_next = rx_ptr_a;
        rx_cnt_next = rx_cnt_a;
        if ((rx_cnt_a == '0) && (rx_ncnt_next != '0)) begin
            rx_ptr_next  = rx_nptr_next;
            rx_cnt_next  = rx_ncnt_next;
            rx_ncnt_next = '0;
        end
        tx_ptr_next = tx_ptr_a;
        tx_cnt_next = tx_cnt_a;
        if ((tx_cnt_a == '0) && (tx_ncnt_next != '0)) begin
            tx_ptr_next  = tx_nptr_next;
            tx_cnt_next  = tx_ncnt_next;
            tx_ncnt_next = '0;
        end

        out_next.end_rx           = (rx_cnt_next == '0);
        out_next.rx_buffers_full  = (rx_cnt_next == '0) && (rx_ncnt_next == '0);
        out_next.end_tx           = (tx_cnt_next == '0);
        out_next.tx_buffers_empty = (tx_cnt_next == '0) && (tx_ncnt_next == '0);
    end

    assign m_valid_next = op_pop || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcode_reg   <= pdc_pkg::WCODE_BYTE;
            rx_ptr_reg  <= '0;
            rx_cnt_reg  <= '0;
            rx_nptr_reg <= '0;
            rx_ncnt_reg <= '0;
            tx_ptr_reg  <= '0;
            tx_cnt_reg  <= '0;
            tx_nptr_reg <= '0;
            tx_ncnt_reg <= '0;
            rx_on_reg   <= 1'b0;
            tx_on_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_write_enable) begin
                wcode_reg <= cfg_write_data;
            end
            if (op_pop) begin
                rx_ptr_reg  <= rx_ptr_next;
                rx_cnt_reg  <= rx_cnt_next;
                rx_nptr_reg <= rx_nptr_next;
                rx_ncnt_reg <= rx_ncnt_next;
                tx_ptr_reg  <= tx_ptr_next;
                tx_cnt_reg  <= tx_cnt_next;
                tx_nptr_reg <= tx_nptr_next;
                tx_ncnt_reg <= tx_ncnt_next;
                rx_on_reg   <= rx_on_next;
                tx_on_reg   <= tx_on_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (op_pop) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/peripheral_dma_channel_pair.sv =====
`default_nettype none

// Receive/transmit DMA channel pair. Each s_ word is a register write, a
// register read, or a receive or transmit request from the peripheral; each
// one yields exactly one m_ word, in order, carrying read data, the issued
// memory address (if any) and the end-of-buffer flags after the step. The
// front decodes words and pushes them into a two-entry queue; the back pops
// one word per cycle while its output register is empty or being taken,
// updates the pointer/count registers (advance, decrement, reload of the next
// pair) and holds the result in an output register. Sustained rate is one
// word per clock with m_ready high; an accepted word is first written into
// the queue, then loaded into the output register, where m_valid rises. With
// m_ready low, three words pile up (two queued, one in the output register)
// before s_ready drops. The unit size (cfg_write_data:
// 0 byte, 1 half-word, else word) should be written only while no word is
// in flight.
module peripheral_dma_channel_pair #(
    parameter int COUNT_WIDTH   = pdc_pkg::COUNT_WIDTH_DEF,
    parameter int ADDRESS_WIDTH = pdc_pkg::ADDRESS_WIDTH_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_write_enable,
    input  wire [pdc_pkg::WCODE_WIDTH-1:0]   cfg_write_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire pdc_pkg::in_t                s_data,
    output logic                             m_valid,
    input  wire                              m_ready,
    output pdc_pkg::out_t                    m_data
);

    pdc_pkg::op_t front_op;
    pdc_pkg::op_t head_op;
    logic         q_full;
    logic         q_not_empty;
    logic         q_pop;

    // Hold s_ready low only while the queue is full.
    assign s_ready = !q_full;

    pdc_front u_front (
        .in_word (s_data),
        .op      (front_op)
    );

    pdc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready),
        .push_op   (front_op),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_op   (head_op)
    );

    pdc_back #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .op_valid         (q_not_empty),
        .op               (head_op),
        .op_pop           (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data)
    );

endmodule

`default_nettype wire

// ===== dv/peripheral_dma_channel_pair_test.sv =====
`timescale 1ns / 100ps

module peripheral_dma_channel_pair_test;
    import pdc_pkg::*;

    localparam int CW = COUNT_WIDTH_DEF;
    localparam int AW = ADDRESS_WIDTH_DEF;

    // The width code left undefined by the encoding; the block treats it as word.
    localparam logic [WCODE_WIDTH-1:0] WCODE_SPARE = 2'd3;

    // Register indexes that decode to nothing.
    localparam logic [INDEX_WIDTH-1:0] REG_HOLE_LOW = 4'hC;
    localparam logic [INDEX_WIDTH-1:0] REG_HOLE_TOP = 4'hF;

    localparam int HOLD_CYCLES    = 400;
    localparam int PRINT_LIMIT    = 40;
    localparam int RANDOM_PER_SET = 220;

    logic aclk             = 1'b0;
    logic aresetn          = 1'b0;
    logic cfg_write_enable = 1'b0;
    logic [WCODE_WIDTH-1:0] cfg_write_data = WCODE_BYTE;
    logic s_valid          = 1'b0;
    logic s_ready;
    in_t  s_data           = '0;
    logic m_valid;
    logic m_ready          = 1'b0;
    out_t m_data;

    peripheral_dma_channel_pair dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Channel pair shadow: mirrors the registers the block should hold.
    // ------------------------------------------------------------------
    logic [WCODE_WIDTH-1:0] unit_code = WCODE_BYTE;
    logic [AW-1:0] rx_addr = '0, rx_addr_next = '0, tx_addr = '0, tx_addr_next = '0;
    logic [CW-1:0] rx_left = '0, rx_left_next = '0, tx_left = '0, tx_left_next = '0;
    logic          rx_enabled = 1'b0, tx_enabled = 1'b0;

    int rx_transfers = 0;
    int tx_transfers = 0;
    int reloads      = 0;

    function automatic logic [AW-1:0] unit_bytes();
        case (unit_code)
            WCODE_BYTE: return 1;
            WCODE_HALF: return 2;
            default:    return 4;
        endcase
    endfunction

    // Apply one word to the shadow registers and return the result word it must produce.
    function automatic out_t channel_step(in_t w);
        out_t r;
        r = '0;
        case (w.command)
            CMD_WRITE: begin
                case (w.reg_index)
                    REG_RX_PTR:      rx_addr      = w.write_data[AW-1:0];
                    REG_RX_CNT:      rx_left      = w.write_data[CW-1:0];
                    REG_TX_PTR:      tx_addr      = w.write_data[AW-1:0];
                    REG_TX_CNT:      tx_left      = w.write_data[CW-1:0];
                    REG_RX_NEXT_PTR: rx_addr_next = w.write_data[AW-1:0];
                    REG_RX_NEXT_CNT: rx_left_next = w.write_data[CW-1:0];
                    REG_TX_NEXT_PTR: tx_addr_next = w.write_data[AW-1:0];
                    REG_TX_NEXT_CNT: tx_left_next = w.write_data[CW-1:0];
                    REG_CONTROL: begin
                        // Disable is applied after enable, so it wins.
                        if (w.write_data[CTRL_RX_ENABLE_BIT])  rx_enabled = 1'b1;
                        if (w.write_data[CTRL_RX_DISABLE_BIT]) rx_enabled = 1'b0;
                        if (w.write_data[CTRL_TX_ENABLE_BIT])  tx_enabled = 1'b1;
                        if (w.write_data[CTRL_TX_DISABLE_BIT]) tx_enabled = 1'b0;
                    end
                    default: ;
                endcase
            end
            CMD_READ: begin
                case (w.reg_index)
                    REG_RX_PTR:      r.read_data = 32'(rx_addr);
                    REG_RX_CNT:      r.read_data = 32'(rx_left);
                    REG_TX_PTR:      r.read_data = 32'(tx_addr);
                    REG_TX_CNT:      r.read_data = 32'(tx_left);
                    REG_RX_NEXT_PTR: r.read_data = 32'(rx_addr_next);
                    REG_RX_NEXT_CNT: r.read_data = 32'(rx_left_next);
                    REG_TX_NEXT_PTR: r.read_data = 32'(tx_addr_next);
                    REG_TX_NEXT_CNT: r.read_data = 32'(tx_left_next);
                    REG_STATUS: begin
                        r.read_data[STAT_RX_ON_BIT] = rx_enabled;
                        r.read_data[STAT_TX_ON_BIT] = tx_enabled;
                    end
                    default: ;
                endcase
            end
            CMD_RX_REQ: begin
                if (rx_enabled && rx_left != 0) begin
                    r.transfer_valid     = 1'b1;
                    r.transfer_to_memory = 1'b1;
                    r.transfer_address   = 32'(rx_addr);
                    rx_addr = rx_addr + unit_bytes();
                    rx_left = rx_left - 1'b1;
                    rx_transfers++;
                end
            end
            default: begin
                if (tx_enabled && tx_left != 0) begin
                    r.transfer_valid   = 1'b1;
                    r.transfer_address = 32'(tx_addr);
                    tx_addr = tx_addr + unit_bytes();
                    tx_left = tx_left - 1'b1;
                    tx_transfers++;
                end
            end
        endcase

        // Reload runs on every word, enabled or not.
        if (rx_left == 0 && rx_left_next != 0) begin
            rx_addr      = rx_addr_next;
            rx_left      = rx_left_next;
            rx_left_next = '0;
            reloads++;
        end
        if (tx_left == 0 && tx_left_next != 0) begin
            tx_addr      = tx_addr_next;
            tx_left      = tx_left_next;
            tx_left_next = '0;
            reloads++;
        end

        r.end_rx           = (rx_left == 0);
        r.rx_buffers_full  = (rx_left == 0) && (rx_left_next == 0);
        r.end_tx           = (tx_left == 0);
        r.tx_buffers_empty = (tx_left == 0) && (tx_left_next == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Word queues and bookkeeping.
    // ------------------------------------------------------------------
    in_t  pending_words[$];
    out_t expected_results[$];

    int words_issued    = 0;
    int words_accepted  = 0;
    int results_checked = 0;
    int mismatches      = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at result %0d: %s got %h want %h", results_checked, what, got,
                     want);
        else if (mismatches == PRINT_LIMIT + 1)
            $display("further mismatches counted but not printed");
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next pending word, hold it until accepted,
    // and predict its result at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(channel_step(s_data));
                words_accepted++;
            end
            // Advance only once the current word is gone; never drop valid under a stall.
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_words.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls, plus a long hold-off counted here on request.
    always @(posedge aclk) begin
        if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES - 1;
            m_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compare every accepted result word with the oldest prediction.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result word with nothing pending", m_data.read_data, '0);
            end else begin
                want = expected_results.pop_front();
                check_field("read_data", m_data.read_data, want.read_data);
                check_field("transfer_valid", m_data.transfer_valid, want.transfer_valid);
                check_field("transfer_address", m_data.transfer_address,
                            want.transfer_address);
                check_field("transfer_to_memory", m_data.transfer_to_memory,
                            want.transfer_to_memory);
                check_field("end_rx", m_data.end_rx, want.end_rx);
                check_field("rx_buffers_full", m_data.rx_buffers_full, want.rx_buffers_full);
                check_field("end_tx", m_data.end_tx, want.end_tx);
                check_field("tx_buffers_empty", m_data.tx_buffers_empty,
                            want.tx_buffers_empty);
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus building.
    // ------------------------------------------------------------------
    task automatic queue_word(command_t op, logic [INDEX_WIDTH-1:0] idx, logic [31:0] d);
        in_t w;
        w.command    = op;
        w.reg_index  = idx;
        w.write_data = d;
        pending_words.push_back(w);
        words_issued++;
    endtask

    // Program one channel with a short buffer and a follow-on buffer, enable it,
    // then drain it with requests mixed with reads and traffic on the other side.
    task automatic queue_buffer_run();
        bit          rx;
        int          cur_len, next_len, reqs;
        logic [31:0] base, d;
        rx       = $urandom_range(1);
        cur_len  = $urandom_range(6);
        next_len = $urandom_range(5);
        base     = ($urandom_range(7) == 0) ? (32'hFFFF_FFF0 | $urandom_range(15)) : $urandom;

        // Counts keep only their low bits; load junk above them now and then.
        d = 32'(cur_len) | (($urandom_range(3) == 0) ? ($urandom << CW) : 32'd0);
        if ($urandom_range(3) == 0) begin
            // Next pair first: an empty channel reloads right away.
            queue_word(CMD_WRITE, rx ? REG_RX_NEXT_PTR : REG_TX_NEXT_PTR, $urandom);
            queue_word(CMD_WRITE, rx ? REG_RX_NEXT_CNT : REG_TX_NEXT_CNT, 32'(next_len));
            queue_word(CMD_WRITE, rx ? REG_RX_PTR : REG_TX_PTR, base);
            queue_word(CMD_WRITE, rx ? REG_RX_CNT : REG_TX_CNT, d);
        end else begin
            queue_word(CMD_WRITE, rx ? REG_RX_PTR : REG_TX_PTR, base);
            queue_word(CMD_WRITE, rx ? REG_RX_CNT : REG_TX_CNT, d);
            queue_word(CMD_WRITE, rx ? REG_RX_NEXT_PTR : REG_TX_NEXT_PTR, $urandom);
            queue_word(CMD_WRITE, rx ? REG_RX_NEXT_CNT : REG_TX_NEXT_CNT, 32'(next_len));
        end

        d = $urandom;
        d[rx ? CTRL_RX_ENABLE_BIT : CTRL_TX_ENABLE_BIT] = 1'b1;
        if ($urandom_range(7) != 0) d[rx ? CTRL_RX_DISABLE_BIT : CTRL_TX_DISABLE_BIT] = 1'b0;
        queue_word(CMD_WRITE, REG_CONTROL, d);

        reqs = cur_len + next_len + $urandom_range(2);
        for (int i = 0; i < reqs; i++) begin
            case ($urandom_range(19))
                0, 1:    queue_word(CMD_READ, 4'($urandom_range(9)), $urandom);
                2:       queue_word(rx ? CMD_TX_REQ : CMD_RX_REQ, 4'($urandom), $urandom);
                3:       queue_word(CMD_READ, REG_STATUS, $urandom);
                default: queue_word(rx ? CMD_RX_REQ : CMD_TX_REQ, 4'($urandom), $urandom);
            endcase
        end
    endtask

    task automatic queue_random(int count);
        int stop_at;
        stop_at = words_issued + count;
        while (words_issued < stop_at) begin
            if ($urandom_range(9) < 7) begin
                queue_buffer_run();
            end else begin
                repeat (3)
                    queue_word(command_t'($urandom_range(3)), 4'($urandom_range(15)),
                               $urandom);
            end
        end
    endtask

    // Wait until every word is in and every result is out, then let the pipe settle.
    task automatic wait_drained();
        do @(negedge aclk);
        while (words_accepted != words_issued || expected_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_unit_width(logic [WCODE_WIDTH-1:0] code);
        @(posedge aclk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= code;
        @(posedge aclk);
        cfg_write_enable <= 1'b0;
        unit_code = code;
    endtask

    task automatic run_random_set(logic [WCODE_WIDTH-1:0] code, int idle, int stall,
                                  bit hold_off);
        wait_drained();
        set_unit_width(code);
        @(negedge aclk);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        if (hold_off) hold_requests++;
        queue_random(RANDOM_PER_SET);
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, directed words, then random sets across widths and idling.
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        set_unit_width(WCODE_BYTE);
        @(negedge aclk);

        // Empty, disabled channel: no transfer.
        queue_word(CMD_READ, REG_STATUS, 32'h0);
        queue_word(CMD_RX_REQ, REG_RX_PTR, 32'hFFFF_FFFF);
        // Receive buffer ends at the top of the address space so the pointer wraps.
        queue_word(CMD_WRITE, REG_RX_PTR, 32'hFFFF_FFFE);
        queue_word(CMD_WRITE, REG_RX_CNT, 32'hABCD_0003);
        queue_word(CMD_WRITE, REG_RX_NEXT_PTR, 32'h1000_0000);
        queue_word(CMD_WRITE, REG_RX_NEXT_CNT, 32'h0000_0001);
        // Enable and disable in one write: stay disabled.
        queue_word(CMD_WRITE, REG_CONTROL,
                   (32'd1 << CTRL_RX_ENABLE_BIT) | (32'd1 << CTRL_RX_DISABLE_BIT));
        queue_word(CMD_RX_REQ, REG_RX_PTR, 32'h0);
        queue_word(CMD_WRITE, REG_CONTROL,
                   (32'd1 << CTRL_RX_ENABLE_BIT) | (32'd1 << CTRL_TX_ENABLE_BIT));
        // Three from the current buffer, one from the reloaded one, then empty.
        repeat (5) queue_word(CMD_RX_REQ, REG_RX_PTR, 32'h0);
        queue_word(CMD_READ, REG_RX_PTR, 32'h0);
        // Next count on an empty channel reloads at once; full-scale count.
        queue_word(CMD_WRITE, REG_TX_PTR, 32'h0000_0000);
        queue_word(CMD_WRITE, REG_TX_NEXT_PTR, 32'hFFFF_FFFF);
        queue_word(CMD_WRITE, REG_TX_NEXT_CNT, 32'hFFFF_FFFF);
        queue_word(CMD_TX_REQ, REG_TX_PTR, 32'h0);
        queue_word(CMD_READ, REG_TX_CNT, 32'h0);
        queue_word(CMD_WRITE, REG_TX_CNT, 32'h0000_0000);
        // Undecoded indexes, write-only control, read-only status.
        queue_word(CMD_WRITE, REG_HOLE_TOP, 32'hFFFF_FFFF);
        queue_word(CMD_READ, REG_HOLE_LOW, 32'h0);
        queue_word(CMD_READ, REG_CONTROL, 32'h0);
        queue_word(CMD_WRITE, REG_STATUS, 32'hFFFF_FFFF);
        queue_word(CMD_READ, REG_STATUS, 32'h0);

        run_random_set(WCODE_WORD,  0,  0,  1'b0);
        run_random_set(WCODE_HALF,  60, 0,  1'b0);
        run_random_set(WCODE_SPARE, 0,  60, 1'b0);
        run_random_set(WCODE_BYTE,  21, 21, 1'b0);
        // Sender keeps offering while the receiver holds off: the block backs up.
        run_random_set(WCODE_WORD,  0,  0,  1'b1);

        wait_drained();
        repeat (8) @(posedge aclk);

        $display("covered %0d words, %0d rx and %0d tx transfers, %0d buffer reloads,",
                 words_accepted, rx_transfers, tx_transfers, reloads);
        $display("all four width codes, four idle patterns and one long receiver hold-off");
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("timeout with %0d words outstanding", words_issued - results_checked);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
